// ===== hw/rtl/srq_pkg.sv =====
// Shared types, widths and status codes for the selective receive queue.
`default_nettype none
package srq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 88;

    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd4;

    localparam logic MODE_PUSH    = 1'b0;
    localparam logic MODE_RECEIVE = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [7:0]  typ;
        logic [15:0] src;
        logic [63:0] payload;
    } t_entry;

    typedef struct packed {
        logic [7:0]  typ;
        logic [15:0] src;
        logic        any_typ;
        logic        any_src;
    } t_key;

    typedef struct packed {
        logic load;
        logic shift;
        logic step;
        logic scan;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/srq_cell.sv =====
// One slot of the queue chain: holds a packet, a scan token and the match compare.
`default_nettype none
module srq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srq_pkg::t_cell_ctl i_ctl,
    input  srq_pkg::t_key     i_key,
    input  srq_pkg::t_entry   i_wr_ent,
    input  logic              i_sel,
    input  srq_pkg::t_entry   i_up_ent,
    input  logic              i_probe,
    output srq_pkg::t_entry   o_ent,
    output logic              o_probe,
    output logic              o_hit
);
    import srq_pkg::*;

    t_entry r_ent;
    logic   r_probe;
    logic   w_match;

    assign w_match = r_ent.valid
                   && (i_key.any_typ || (r_ent.typ == i_key.typ))
                   && (i_key.any_src || (r_ent.src == i_key.src));
    assign o_hit   = i_ctl.scan && r_probe && w_match;
    assign o_ent   = r_ent;
    assign o_probe = r_probe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
            r_probe     <= 1'b0;
        end else begin
            r_probe <= i_ctl.step && i_probe;
            if (i_ctl.shift) begin
                r_ent <= i_up_ent;
            end else if (i_ctl.load && i_sel) begin
                r_ent <= i_wr_ent;
            end else if (o_hit) begin
                r_ent.valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/selective_receive_queue_core.sv =====
// Top level of the selective receive queue: cell chain, sequencer and output register.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | arrival_type 8, arrival_source 16,              | mode 1
//           |     | arrival_payload 64, wanted_type 8,              |
//           |     | wanted_source 16, any_type 1, any_source 1, pad |
//  m_axis   | out | found_source 16, found_type 8, found_payload 64 | status 3
//
// A push, or a receive on an empty store, passes through the accepting state and then the
// load of the output register. A delivery scans slot by slot, reclaims the emptied slots at
// the head and then loads the output register; a receive with no match scans every occupied
// slot before that load. The scan token walking the cell chain bounds the scan.
// The store is the row of cells itself; cell 0 is always the oldest slot.
// Reset clears the valid bits, the occupancy and the control state.
// An item is taken only when the previous one has finished; a stalled output holds.
`default_nettype none
module selective_receive_queue_core #(
    parameter int unsigned QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [srq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // a_type, a_src, a_pay, w_type, w_src, any_t, any_s
    input  logic [0:0]                       s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [srq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // found_source, found_type, found_payload
    output logic [srq_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);
    import srq_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RECLAIM,
        S_RESULT
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [PW-1:0]          r_pos;
    t_key                   r_key;
    logic [STATUS_W-1:0]    r_res_status;
    logic [OUT_TDATA_W-1:0] r_res_data;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic       w_accept;
    logic       w_mode;
    logic       w_full;
    logic       w_start;
    logic       w_any_hit;
    logic       w_last_pos;
    t_cell_ctl  w_ctl;
    t_entry     w_wr_ent;
    t_key       w_in_key;
    t_entry     w_found;
    t_entry     w_ent   [QUEUE_DEPTH];
    logic       w_probe [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_hit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser[0];
    assign w_full        = (r_count == CW'(QUEUE_DEPTH));
    assign w_start       = w_accept && (w_mode == MODE_RECEIVE) && (r_count != '0);
    assign w_any_hit     = |w_hit;
    assign w_last_pos    = ((CW'(r_pos) + CW'(1)) == r_count);

    assign w_wr_ent.valid   = 1'b1;
    assign w_wr_ent.typ     = s_axis_tdata[7:0];
    assign w_wr_ent.src     = s_axis_tdata[23:8];
    assign w_wr_ent.payload = s_axis_tdata[87:24];

    assign w_in_key.typ     = s_axis_tdata[95:88];
    assign w_in_key.src     = s_axis_tdata[111:96];
    assign w_in_key.any_typ = s_axis_tdata[112];
    assign w_in_key.any_src = s_axis_tdata[113];

    assign w_ctl.load  = w_accept && (w_mode == MODE_PUSH) && !w_full;
    assign w_ctl.step  = w_start || (r_state == S_SCAN);
    assign w_ctl.scan  = (r_state == S_SCAN);
    assign w_ctl.shift = (r_state == S_RECLAIM) && (r_count != '0) && !w_ent[0].valid;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_entry w_up;
        logic   w_pin;
        if (k == QUEUE_DEPTH - 1) begin : g_end
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = w_ent[k+1];
        end
        if (k == 0) begin : g_head
            assign w_pin = w_start;
        end else begin : g_body
            assign w_pin = w_probe[k-1];
        end
        srq_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_key    (r_key),
            .i_wr_ent (w_wr_ent),
            .i_sel    (r_count == CW'(k)),
            .i_up_ent (w_up),
            .i_probe  (w_pin),
            .o_ent    (w_ent[k]),
            .o_probe  (w_probe[k]),
            .o_hit    (w_hit[k])
        );
    end

    always_comb begin
        w_found = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (w_hit[k]) begin
                w_found = w_found | w_ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_data <= '0;
                        r_key      <= w_in_key;
                        r_pos      <= '0;
                        if (w_mode == MODE_PUSH) begin
                            r_state <= S_RESULT;
                            if (w_full) begin
                                r_res_status <= ST_DROPPED;
                            end else begin
                                r_res_status <= ST_PUSHED;
                                r_count      <= r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_RESULT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_any_hit) begin
                        r_res_status <= ST_DELIVERED;
                        r_res_data   <= {w_found.payload, w_found.typ, w_found.src};
                        r_state      <= S_RECLAIM;
                    end else if (w_last_pos) begin
                        r_res_status <= ST_NOMATCH;
                        r_state      <= S_RESULT;
                    end else begin
                        r_pos <= r_pos + PW'(1);
                    end
                end
                S_RECLAIM: begin
                    if (w_ctl.shift) begin
                        r_count <= r_count - CW'(1);
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_data   <= r_res_data;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy exceeds the queue depth");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && (r_count != '0) |-> w_ent[0].valid)
        else $error("idle queue has a hole at its head");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matched in one cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start processing");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the selective receive queue core.
`timescale 1ns / 100ps
module tb_top;

    import srq_pkg::*;

    localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
    localparam int unsigned RANDOM_OPS   = 950;
    localparam int unsigned SETTLE_CYC   = 2 * DEPTH + 8;
    localparam int unsigned STALL_LIMIT  = 5000;

    typedef struct packed {
        logic        mode;
        logic [7:0]  a_type;
        logic [15:0] a_src;
        logic [63:0] a_pay;
        logic [7:0]  w_type;
        logic [15:0] w_src;
        logic        any_t;
        logic        any_s;
    } packet_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [15:0]         src;
        logic [7:0]          typ;
        logic [63:0]         pay;
    } queue_reply_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;  // a_type, a_src, a_pay, w_type, w_src, any_t, any_s
    logic [0:0]              s_axis_tuser = '0;  // mode
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;       // found_source, found_type, found_payload
    logic [STATUS_W-1:0]     m_axis_tuser;       // status

    packet_op_t   packet_ops[$];
    queue_reply_t due_replies[$];

    // Shadow copy of the mailbox contents.
    bit           q_valid[DEPTH];
    logic [7:0]   q_typ[DEPTH];
    logic [15:0]  q_src[DEPTH];
    logic [63:0]  q_pay[DEPTH];
    int unsigned  q_head = 0;
    int unsigned  q_tail = 0;
    int unsigned  q_count = 0;

    logic [7:0]   type_pool[3];
    logic [15:0]  src_pool[3];

    int           mismatches = 0;
    logic         in_taken = 1'b0;
    int           burst_left = 1;
    int           gap_left = 0;
    int unsigned  rx_cycle = 0;
    int unsigned  rx_style = 0;
    int unsigned  idle_cycles = 0;

    selective_receive_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50) begin
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        end
    endtask

    task automatic reclaim_holes();
        while (q_count > 0 && !q_valid[q_head]) begin
            q_head = (q_head + 1) % DEPTH;
            q_count--;
        end
    endtask

    task automatic model_queue_op(input packet_op_t op, output queue_reply_t r);
        int unsigned s;
        bit hit;
        r = '0;
        hit = 1'b0;
        if (op.mode == MODE_PUSH) begin
            if (q_count >= DEPTH) begin
                r.status = ST_DROPPED;
            end else begin
                q_valid[q_tail] = 1'b1;
                q_typ[q_tail] = op.a_type;
                q_src[q_tail] = op.a_src;
                q_pay[q_tail] = op.a_pay;
                q_tail = (q_tail + 1) % DEPTH;
                q_count++;
                r.status = ST_PUSHED;
            end
        end else begin
            reclaim_holes();
            if (q_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_NOMATCH;
                for (int i = 0; i < q_count && !hit; i++) begin
                    s = (q_head + i) % DEPTH;
                    if (q_valid[s] && (op.any_t || q_typ[s] == op.w_type)
                            && (op.any_s || q_src[s] == op.w_src)) begin
                        hit = 1'b1;
                        r.status = ST_DELIVERED;
                        r.src = q_src[s];
                        r.typ = q_typ[s];
                        r.pay = q_pay[s];
                        q_valid[s] = 1'b0;
                    end
                end
                if (hit) reclaim_holes();
            end
        end
    endtask

    function automatic packet_op_t make_push(input logic [7:0] t, input logic [15:0] s,
                                             input logic [63:0] p);
        packet_op_t op;
        op.mode = MODE_PUSH;
        op.a_type = t;
        op.a_src = s;
        op.a_pay = p;
        op.w_type = 8'($urandom);
        op.w_src = 16'($urandom);
        op.any_t = 1'($urandom_range(0, 1));
        op.any_s = 1'($urandom_range(0, 1));
        return op;
    endfunction

    function automatic packet_op_t make_recv(input logic [7:0] t, input logic [15:0] s,
                                             input logic at, input logic as);
        packet_op_t op;
        op.mode = MODE_RECEIVE;
        op.a_type = 8'($urandom);
        op.a_src = 16'($urandom);
        op.a_pay = {$urandom, $urandom};
        op.w_type = t;
        op.w_src = s;
        op.any_t = at;
        op.any_s = as;
        return op;
    endfunction

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 99) < 80) return type_pool[$urandom_range(0, 2)];
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_src();
        if ($urandom_range(0, 99) < 80) return src_pool[$urandom_range(0, 2)];
        return 16'($urandom);
    endfunction

    // Sender: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        packet_op_t op;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (packet_ops.size() > 0) begin
                op = packet_ops.pop_front();
                s_axis_tdata <= {6'b0, op.any_s, op.any_t, op.w_src, op.w_type,
                                 op.a_pay, op.a_src, op.a_type};
                s_axis_tuser <= op.mode;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready always, at random, or in a repeating pattern; the style is redrawn at random.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 2);
        case (rx_style)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_axis_tready <= (rx_cycle % 13) < 3;
            end
        endcase
    end

    always @(posedge i_clk) begin
        packet_op_t op;
        queue_reply_t got;
        queue_reply_t want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.src = m_axis_tdata[15:0];
            got.typ = m_axis_tdata[23:16];
            got.pay = m_axis_tdata[87:24];
            if (due_replies.size() == 0) begin
                report("result with nothing due, status", 64'(got.status), 64'(0));
            end else begin
                want = due_replies.pop_front();
                if (got.status !== want.status) begin
                    report("status", 64'(got.status), 64'(want.status));
                end
                if (got.src !== want.src) report("found_source", 64'(got.src), 64'(want.src));
                if (got.typ !== want.typ) report("found_type", 64'(got.typ), 64'(want.typ));
                if (got.pay !== want.pay) report("found_payload", got.pay, want.pay);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            op.a_type = s_axis_tdata[7:0];
            op.a_src = s_axis_tdata[23:8];
            op.a_pay = s_axis_tdata[87:24];
            op.w_type = s_axis_tdata[95:88];
            op.w_src = s_axis_tdata[111:96];
            op.any_t = s_axis_tdata[112];
            op.any_s = s_axis_tdata[113];
            op.mode = s_axis_tuser[0];
            model_queue_op(op, want);
            due_replies.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int push_pct;
        int pcts[3];
        pcts = '{25, 50, 85};
        push_pct = 50;
        type_pool = '{8'h00, 8'hFF, 8'($urandom)};
        src_pool = '{16'h0000, 16'hFFFF, 16'($urandom)};

        // Receives on an empty store, with and without wildcards.
        packet_ops.push_back(make_recv(8'h00, 16'h0000, 1'b1, 1'b1));
        packet_ops.push_back(make_recv(8'hFF, 16'hFFFF, 1'b0, 1'b0));
        // Fill the store completely, extremes first.
        packet_ops.push_back(make_push(8'h00, 16'h0000, 64'h0));
        packet_ops.push_back(make_push(8'hFF, 16'hFFFF, {64{1'b1}}));
        for (int i = 2; i < DEPTH; i++) begin
            packet_ops.push_back(make_push((i % 2) ? 8'h22 : 8'h11,
                                           (i % 3 == 0) ? 16'h0200 : 16'h0100,
                                           {$urandom, $urandom}));
        end
        // Full store drops the push.
        packet_ops.push_back(make_push(8'h5A, 16'hA5A5, {$urandom, $urandom}));
        packet_ops.push_back(make_recv(8'h33, 16'h0100, 1'b0, 1'b0));
        // Match in the middle leaves a hole; then another hole next to the head.
        packet_ops.push_back(make_recv(8'h22, 16'h0200, 1'b0, 1'b0));
        packet_ops.push_back(make_recv(8'h77, 16'hFFFF, 1'b1, 1'b0));
        // Match at the head reclaims the hole behind it.
        packet_ops.push_back(make_recv(8'h00, 16'h1234, 1'b1, 1'b1));
        packet_ops.push_back(make_recv(8'hFF, 16'h4321, 1'b0, 1'b1));
        packet_ops.push_back(make_push(8'hFF, 16'h0000, {$urandom, $urandom}));

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) push_pct = pcts[$urandom_range(0, 2)];
            if ($urandom_range(0, 99) < push_pct) begin
                packet_ops.push_back(make_push(pick_type(), pick_src(), {$urandom, $urandom}));
            end else begin
                packet_ops.push_back(make_recv(pick_type(), pick_src(),
                                               $urandom_range(0, 99) < 30,
                                               $urandom_range(0, 99) < 30));
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (packet_ops.size() > 0 || s_axis_tvalid) @(negedge i_clk);
        while (due_replies.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (due_replies.size() > 0) begin
            report("results never delivered", 64'(due_replies.size()), 64'(0));
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
